>>> rtl/afz_pkg.sv
package afz_pkg;

   localparam int unsigned EYE_COUNT = 2;

   // field and datapath widths
   localparam int unsigned SCR_W    = 10;
   localparam int unsigned FRM_W    = 12;
   localparam int unsigned SAR_W    = 16;
   localparam int unsigned DIM_W    = 16;
   localparam int unsigned ZOOM_W   = 24;
   localparam int unsigned OFF_W    = 24;
   localparam int unsigned PROD_W   = 40;
   localparam int unsigned DIVN_W   = 42;
   localparam int unsigned DIVD_W   = 17;
   localparam int unsigned DIV_CNT_W = 5;

   localparam logic [SCR_W-1:0]  TOP_WIDTH  = 10'd400;
   localparam logic [SCR_W-1:0]  TOP_HEIGHT = 10'd240;
   localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 24'hFFFFFF;
   localparam logic [ZOOM_W-1:0] ZOOM_ONE   = 24'h010000;

   localparam logic [1:0] REG_PIXEL_PERFECT = 2'd0;
   localparam logic [1:0] REG_SIDE_BY_SIDE  = 2'd1;
   localparam logic [1:0] REG_SINGLE_TRACK  = 2'd2;

   localparam logic OP_FIT    = 1'b0;
   localparam logic OP_RESIZE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VW,
      ST_VH,
      ST_DISP,
      ST_CLASS,
      ST_CMP,
      ST_RNUM,
      ST_DIV,
      ST_OFFX,
      ST_OFFY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] num;
      logic [DIVD_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ZOOM_W-1:0] quot;
   } div_rsp_type;

endpackage

>>> rtl/afz_mul.sv
module afz_mul (
   input  logic                        clock,
   input  logic [afz_pkg::DIM_W-1:0]   mul_a,
   input  logic [afz_pkg::ZOOM_W-1:0]  mul_b,
   output logic [afz_pkg::PROD_W-1:0]  mul_p
);
   import afz_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

>>> rtl/afz_div.sv
module afz_div (
   input  logic                 clock,
   input  logic                 reset,
   input  afz_pkg::div_req_type div_req,
   output afz_pkg::div_rsp_type div_rsp
);
   import afz_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0]    den_ff, den_in;
   logic [DIVD_W-1:0]    rem_ff, rem_in;
   logic [ZOOM_W-1:0]    quot_ff, quot_in;
   logic [DIVD_W:0]      trial;
   logic                 ge;

   // one restoring step per cycle; dividend bits shift out as quotient bits shift in
   assign trial = {rem_ff, quot_ff[ZOOM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         den_in = div_req.den;
         // high part already holds the divisor: quotient exceeds the zoom range
         if (div_req.num[DIVN_W-1:ZOOM_W] >= {1'b0, div_req.den}) begin
            quot_in = ZOOM_MAX;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = div_req.num[DIVN_W-2:ZOOM_W];
            quot_in = div_req.num[ZOOM_W-1:0];
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? DIVD_W'(trial - {1'b0, den_ff}) : trial[DIVD_W-1:0];
         quot_in = {quot_ff[ZOOM_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(ZOOM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> rtl/aspect_fit_zoom_offset_core.sv
// One transaction at a time; start is taken again in the cycle after the result strobe.
// A fit or resize waits on the 24-step divider unless the zoom saturates; a resize that
// clamps to zero, a right-eye copy, a zero size and a pixel-perfect fit skip the divider.
// Reset (synchronous, active high) clears both eyes' zoom and offsets and selects
// fit-to-screen, no side-by-side, single track. rsp_valid strobes; the receiver cannot stall.
module aspect_fit_zoom_offset_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic        req_eye,
   input  logic [9:0]  req_screen_w,
   input  logic [9:0]  req_screen_h,
   input  logic [11:0] req_frame_w,
   input  logic [11:0] req_frame_h,
   input  logic [11:0] req_codec_w,
   input  logic [11:0] req_codec_h,
   input  logic [15:0] req_sar_w,
   input  logic [15:0] req_sar_h,
   input  logic signed [15:0] req_width_delta,
   // result channel
   output logic        rsp_valid,
   output logic [23:0] rsp_zoom,
   output logic signed [23:0] rsp_x_offset,
   output logic signed [23:0] rsp_y_offset,
   output logic        rsp_updated,
   output logic        rsp_nearest_filter,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import afz_pkg::*;

   // ---------------------------------------------------------------------------------------
   // mode registers
   // ---------------------------------------------------------------------------------------
   logic       pp_ff, sbs_ff, single_ff;
   logic [1:0] reg_idx;
   logic       reg_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign reg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff     <= 1'b0;
         sbs_ff    <= 1'b0;
         single_ff <= 1'b1;
      end else if (reg_wr) begin
         case (reg_idx)
            REG_PIXEL_PERFECT: pp_ff     <= pwdata[0];
            REG_SIDE_BY_SIDE:  sbs_ff    <= pwdata[0];
            REG_SINGLE_TRACK:  single_ff <= pwdata[0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PIXEL_PERFECT: prdata = {31'b0, pp_ff};
         REG_SIDE_BY_SIDE:  prdata = {31'b0, sbs_ff};
         REG_SINGLE_TRACK:  prdata = {31'b0, single_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // transaction capture
   // ---------------------------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      accept;

   logic               op_ff, eye_ff;
   logic [SCR_W-1:0]   sw_ff, sh_ff;
   logic [FRM_W-1:0]   w_ff, h_ff;
   logic [SAR_W-1:0]   sarw_ff, sarh_ff;
   logic signed [15:0] chg_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // pick the frame size, falling back to the codec size; a zero aspect factor means 1.0
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         eye_ff <= req_eye;
         sw_ff  <= req_screen_w;
         sh_ff  <= req_screen_h;
         if (req_frame_w == '0 || req_frame_h == '0) begin
            w_ff <= req_codec_w;
            h_ff <= req_codec_h;
         end else begin
            w_ff <= req_frame_w;
            h_ff <= req_frame_h;
         end
         sarw_ff <= (req_sar_w == '0) ? SAR_W'(256) : req_sar_w;
         sarh_ff <= (req_sar_h == '0) ? SAR_W'(256) : req_sar_h;
         chg_ff  <= req_width_delta;
      end
   end

   // ---------------------------------------------------------------------------------------
   // shared multiplier and divider
   // ---------------------------------------------------------------------------------------
   logic [DIM_W-1:0]  mul_a;
   logic [ZOOM_W-1:0] mul_b;
   logic [PROD_W-1:0] mul_p;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   afz_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   afz_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------------------------------
   // per-eye state and work registers
   // ---------------------------------------------------------------------------------------
   logic [ZOOM_W-1:0] zoom_ff [EYE_COUNT];
   logic [ZOOM_W-1:0] zoom_in [EYE_COUNT];
   logic [OFF_W-1:0]  xoff_ff [EYE_COUNT];
   logic [OFF_W-1:0]  xoff_in [EYE_COUNT];
   logic [OFF_W-1:0]  yoff_ff [EYE_COUNT];
   logic [OFF_W-1:0]  yoff_in [EYE_COUNT];

   logic [DIM_W-1:0] vw_ff, vw_in, vh_ff, vh_in;
   logic [25:0]      lhs_ff, lhs_in;
   logic             upd_ff, upd_in;
   logic             near_ff, near_in;
   logic             ppath_ff, ppath_in;

   // presentation size: round the Q8.8 product half up and saturate at 16 bits
   function automatic logic [DIM_W-1:0] scale_sat(input logic [PROD_W-1:0] p);
      logic [28:0] t;
      t = p[28:0] + 29'd128;
      return (t[28:24] != '0) ? {DIM_W{1'b1}} : t[23:8];
   endfunction

   function automatic logic [OFF_W-1:0] sat_off(input logic signed [43:0] v);
      if (v > 44'sd8388607) begin
         return 24'h7FFFFF;
      end else if (v < -44'sd8388608) begin
         return 24'h800000;
      end
      return v[OFF_W-1:0];
   endfunction

   logic allowed;
   assign allowed = (vw_ff != '0) && (vh_ff != '0) && !vw_ff[0] && !vh_ff[0] &&
                    (vw_ff <= DIM_W'(TOP_WIDTH)) && (vh_ff <= DIM_W'(TOP_HEIGHT));

   // ---------------------------------------------------------------------------------------
   // offset unit, shared by the x pass and the y pass
   // ---------------------------------------------------------------------------------------
   logic                is_x, wide;
   logic [SCR_W-1:0]    s_sel, top_sel;
   logic [DIM_W-1:0]    v_sel;
   logic signed [43:0]  term, pp_core, base, diff, rnd9, rnd10, off_raw;
   logic [OFF_W-1:0]    off_sat;

   assign is_x    = (state_ff == ST_OFFX);
   assign s_sel   = is_x ? sw_ff : sh_ff;
   assign v_sel   = is_x ? vw_ff : vh_ff;
   assign top_sel = is_x ? TOP_WIDTH : TOP_HEIGHT;
   // the side-by-side x offset works on twice the screen width
   assign wide    = sbs_ff && is_x;

   always_comb begin
      term    = ($signed({34'b0, top_sel}) - $signed({34'b0, s_sel})) <<< 8;
      pp_core = ($signed({34'b0, s_sel}) - $signed({28'b0, v_sel})) <<< 7;
      base    = wide ? $signed({17'b0, s_sel, 17'b0}) : $signed({18'b0, s_sel, 16'b0});
      diff    = base - $signed({4'b0, mul_p});
      rnd9    = (diff + 44'sd256) >>> 9;
      rnd10   = (diff + 44'sd512) >>> 10;
      if (ppath_ff) begin
         off_raw = pp_core + term;
      end else if (sbs_ff) begin
         off_raw = wide ? rnd10 : rnd9;
      end else begin
         off_raw = rnd9 + term;
      end
      off_sat = sat_off(off_raw);
   end

   // ---------------------------------------------------------------------------------------
   // resize numerator and fit-zoom selection
   // ---------------------------------------------------------------------------------------
   logic signed [41:0] rnum;
   logic               rnum_pos;
   logic               fit_w;
   logic [27:0]        fnum;
   logic [DIM_W-1:0]   fden;

   assign rnum     = $signed({2'b0, mul_p}) + $signed({{10{chg_ff[15]}}, chg_ff, 16'b0});
   assign rnum_pos = !rnum[41] && (rnum != '0);

   // width limits the fit when vw*sh >= vh*sw (twice vh*sw in side-by-side)
   assign fit_w = sbs_ff ? ({1'b0, lhs_ff} >= {mul_p[25:0], 1'b0})
                         : (lhs_ff >= mul_p[25:0]);

   always_comb begin
      if (fit_w) begin
         fnum = sbs_ff ? {1'b0, sw_ff, 17'b0} : {2'b0, sw_ff, 16'b0};
         fden = vw_ff;
      end else begin
         fnum = {2'b0, sh_ff, 16'b0};
         fden = vh_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      zoom_in  = zoom_ff;
      xoff_in  = xoff_ff;
      yoff_in  = yoff_ff;
      vw_in    = vw_ff;
      vh_in    = vh_ff;
      lhs_in   = lhs_ff;
      upd_in   = upd_ff;
      near_in  = near_ff;
      ppath_in = ppath_ff;
      mul_a    = vw_ff;
      mul_b    = zoom_ff[eye_ff];
      div_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               upd_in   = 1'b1;
               ppath_in = 1'b0;
               state_in = ST_VW;
            end
         end
         ST_VW: begin
            mul_a    = sarw_ff;
            mul_b    = ZOOM_W'(w_ff);
            state_in = ST_VH;
         end
         ST_VH: begin
            mul_a    = sarh_ff;
            mul_b    = ZOOM_W'(h_ff);
            vw_in    = scale_sat(mul_p);
            state_in = ST_DISP;
         end
         ST_DISP: begin
            vh_in    = scale_sat(mul_p);
            mul_a    = vw_ff;
            mul_b    = ZOOM_W'(sh_ff);
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            near_in = pp_ff && !sbs_ff && allowed;
            if (op_ff == OP_FIT && eye_ff && (sbs_ff || single_ff)) begin
               // right eye follows the left eye
               zoom_in[1] = zoom_ff[0];
               xoff_in[1] = xoff_ff[0];
               yoff_in[1] = yoff_ff[0];
               state_in   = ST_DONE;
            end else if (vw_ff == '0 || vh_ff == '0) begin
               upd_in   = 1'b0;
               state_in = ST_DONE;
            end else if (op_ff == OP_RESIZE) begin
               mul_a    = vw_ff;
               mul_b    = zoom_ff[eye_ff];
               state_in = ST_RNUM;
            end else if (!sbs_ff && pp_ff && allowed) begin
               zoom_in[eye_ff] = ZOOM_ONE;
               ppath_in        = 1'b1;
               state_in        = ST_OFFX;
            end else begin
               lhs_in   = mul_p[25:0];
               mul_a    = vh_ff;
               mul_b    = ZOOM_W'(sw_ff);
               state_in = ST_CMP;
            end
         end
         ST_RNUM: begin
            if (rnum_pos) begin
               div_req.start = 1'b1;
               div_req.num   = {rnum[40:0], 1'b0} + DIVN_W'(vw_ff);
               div_req.den   = {vw_ff, 1'b0};
               state_in      = ST_DIV;
            end else begin
               // shrinking past zero clamps the zoom
               zoom_in[eye_ff] = '0;
               state_in        = ST_DONE;
            end
         end
         ST_CMP: begin
            div_req.start = 1'b1;
            div_req.num   = {13'b0, fnum, 1'b0} + DIVN_W'(fden);
            div_req.den   = {fden, 1'b0};
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            // start vw*z as soon as the quotient lands
            mul_a = vw_ff;
            mul_b = div_rsp.quot;
            if (div_rsp.done) begin
               zoom_in[eye_ff] = div_rsp.quot;
               state_in        = (op_ff == OP_RESIZE) ? ST_DONE : ST_OFFX;
            end
         end
         ST_OFFX: begin
            mul_a           = vh_ff;
            mul_b           = zoom_ff[eye_ff];
            xoff_in[eye_ff] = off_sat;
            state_in        = ST_OFFY;
         end
         ST_OFFY: begin
            yoff_in[eye_ff] = off_sat;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < EYE_COUNT; i++) begin
            zoom_ff[i] <= '0;
            xoff_ff[i] <= '0;
            yoff_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         zoom_ff  <= zoom_in;
         xoff_ff  <= xoff_in;
         yoff_ff  <= yoff_in;
      end
   end

   always_ff @(posedge clock) begin
      vw_ff    <= vw_in;
      vh_ff    <= vh_in;
      lhs_ff   <= lhs_in;
      upd_ff   <= upd_in;
      near_ff  <= near_in;
      ppath_ff <= ppath_in;
   end

   // ---------------------------------------------------------------------------------------
   // result: the addressed eye's state after the transaction
   // ---------------------------------------------------------------------------------------
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_zoom           = zoom_ff[eye_ff];
   assign rsp_x_offset       = $signed(xoff_ff[eye_ff]);
   assign rsp_y_offset       = $signed(yoff_ff[eye_ff]);
   assign rsp_updated        = upd_ff;
   assign rsp_nearest_filter = near_ff;

endmodule
